@@ rtl/olns_pkg.sv @@
`timescale 1ns / 1ps
package olns_pkg;

	localparam int MAX_LEAVES = 1024;
	localparam int COORD_BITS = 21;
	localparam int CODE_W     = 3 * COORD_BITS;
	localparam int LEVEL_W    = 5;
	localparam int IDX_W      = $clog2(MAX_LEAVES);
	localparam int CNT_W      = IDX_W + 1;
	localparam int NUM_NB     = 26;
	localparam int NB_W       = $clog2(NUM_NB);
	localparam int OUT_IDX_W  = 10;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(21);

	typedef struct packed {
		logic [1:0]        op;
		logic [CODE_W-1:0] morton;
	} cmd_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] result_index;
		logic                 valid_res;
		logic                 table_full;
		logic                 last;
	} res_t;

	typedef struct packed {
		logic             load;
		logic             cmp;
		logic [IDX_W-1:0] idx;
	} match_ctl_t;

	function automatic logic [LEVEL_W-1:0] eff_level(input logic [LEVEL_W-1:0] lv);
		logic [LEVEL_W-1:0] r;
		r = lv;
		if (lv == '0) begin
			r = LEVEL_W'(1);
		end else if (lv > LEVEL_W'(COORD_BITS)) begin
			r = LEVEL_W'(COORD_BITS);
		end
		return r;
	endfunction

	function automatic logic [CODE_W-1:0] level_mask(input logic [LEVEL_W-1:0] lv);
		logic [CODE_W-1:0] m;
		for (int b = 0; b < COORD_BITS; b++) begin
			for (int a = 0; a < 3; a++) begin
				m[3*b+a] = (LEVEL_W'(b) < lv);
			end
		end
		return m;
	endfunction

	function automatic logic [COORD_BITS-1:0] gather3(input logic [CODE_W-1:0] code,
	                                                 input int axis);
		logic [COORD_BITS-1:0] c;
		for (int b = 0; b < COORD_BITS; b++) begin
			c[b] = code[3*b+axis];
		end
		return c;
	endfunction

	function automatic logic [CODE_W-1:0] interleave(input logic [COORD_BITS-1:0] x,
	                                                input logic [COORD_BITS-1:0] y,
	                                                input logic [COORD_BITS-1:0] z);
		logic [CODE_W-1:0] r;
		for (int b = 0; b < COORD_BITS; b++) begin
			r[3*b]   = x[b];
			r[3*b+1] = y[b];
			r[3*b+2] = z[b];
		end
		return r;
	endfunction

endpackage

@@ rtl/olns_leaf_ram.sv @@
`timescale 1ns / 1ps
module olns_leaf_ram import olns_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [CODE_W-1:0] wdata,
	input  logic              re,
	input  logic [IDX_W-1:0]  raddr,
	output logic [CODE_W-1:0] rdata
);

	logic [CODE_W-1:0] mem [MAX_LEAVES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/olns_lane_match.sv @@
`timescale 1ns / 1ps
module olns_lane_match import olns_pkg::*; (
	input  logic                              clk,
	input  logic                              arst_n,
	input  match_ctl_t                        ctl,
	input  logic [CODE_W-1:0]                 query_code,
	input  logic [LEVEL_W-1:0]                level,
	input  logic [CODE_W-1:0]                 rd_data,
	output logic [NUM_NB-1:0]                 hit,
	output logic [NUM_NB-1:0][IDX_W-1:0]      hit_idx
);

	logic [2:0][COORD_BITS-1:0] xs_q, ys_q, zs_q;
	logic [NUM_NB-1:0]          lane_ok_q;
	logic [NUM_NB-1:0]          hit_q;
	logic [NUM_NB-1:0][IDX_W-1:0] idx_q;

	logic [COORD_BITS-1:0] cx, cy, cz, lim;
	logic [2:0]            okx, oky, okz;
	logic [NUM_NB-1:0]     lane_ok_d;
	logic [NUM_NB-1:0]     lane_eq;

	always_comb begin
		cx  = gather3(query_code, 0);
		cy  = gather3(query_code, 1);
		cz  = gather3(query_code, 2);
		lim = COORD_BITS'(((COORD_BITS+1)'(1) << level) - (COORD_BITS+1)'(1));
		okx = {cx != lim, 1'b1, cx != '0};
		oky = {cy != lim, 1'b1, cy != '0};
		okz = {cz != lim, 1'b1, cz != '0};
	end

	// lanes walk dx, dy, dz from -1 to +1, center cell left out
	for (genvar k = 0; k < NUM_NB; k++) begin : g_lane
		localparam int J  = (k < 13) ? k : k + 1;
		localparam int XI = J / 9;
		localparam int YI = (J / 3) % 3;
		localparam int ZI = J % 3;

		assign lane_ok_d[k] = okx[XI] & oky[YI] & okz[ZI];
		assign lane_eq[k]   = lane_ok_q[k] &&
		                      (interleave(xs_q[XI], ys_q[YI], zs_q[ZI]) == rd_data);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			xs_q      <= {cx + COORD_BITS'(1), cx, cx - COORD_BITS'(1)};
			ys_q      <= {cy + COORD_BITS'(1), cy, cy - COORD_BITS'(1)};
			zs_q      <= {cz + COORD_BITS'(1), cz, cz - COORD_BITS'(1)};
			lane_ok_q <= lane_ok_d;
		end
	end

	// scan runs upward, so a later duplicate overwrites an earlier one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
		end else if (ctl.load) begin
			hit_q <= '0;
		end else if (ctl.cmp) begin
			hit_q <= hit_q | lane_eq;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_NB; k++) begin
			if (ctl.cmp && lane_eq[k]) begin
				idx_q[k] <= ctl.idx;
			end
		end
	end

	assign hit     = hit_q;
	assign hit_idx = idx_q;

endmodule

@@ rtl/octree_leaf_neighbour_search.sv @@
`timescale 1ns / 1ps
// Insert: one result beat the cycle after start; a new command may follow at once.
// Query: busy through scan, drain, emit (empty table: emit only); one RAM entry per cycle
// (all 26 neighbor codes compared per entry), a drain state, one emit slot per offset.
// Clear and unused opcodes give no result and leave the block idle.
// arst_n clears the leaf count and resets the level to 21; RAM contents stay.
// Result beats last one cycle each and cannot be stalled by the receiver.
module octree_leaf_neighbour_search import olns_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  cmd_t                cmd,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [LEVEL_W-1:0]  cfg_data,
	output logic                result_strobe,
	output res_t                result
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [LEVEL_W-1:0] level_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   rd_ptr_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [NB_W-1:0]    lane_q;
	logic               strobe_q;
	res_t               res_q;

	logic [LEVEL_W-1:0]        lv;
	logic [CODE_W-1:0]         code_m;
	logic                      accept;
	logic                      do_insert;
	logic                      full;
	logic                      ram_re;
	logic [CODE_W-1:0]         rd_data;
	match_ctl_t                mctl;
	logic [NUM_NB-1:0]         hit;
	logic [NUM_NB-1:0][IDX_W-1:0] hit_idx;
	logic [NUM_NB-1:0]         later;
	logic                      scan_done;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign lv        = eff_level(level_q);
	assign code_m    = cmd.morton & level_mask(lv);
	assign full      = (count_q == CNT_W'(MAX_LEAVES));
	assign do_insert = accept && (cmd.op == OP_INSERT) && !full;
	assign ram_re    = (state_q == ST_SCAN);
	assign scan_done = ({1'b0, rd_ptr_q} == count_q - CNT_W'(1));

	assign mctl.load = accept && (cmd.op == OP_QUERY);
	assign mctl.cmp  = rd_vld_s1;
	assign mctl.idx  = rd_idx_s1;

	always_comb begin
		for (int k = 0; k < NUM_NB; k++) begin
			later[k] = (NB_W'(k) > lane_q);
		end
	end

	olns_leaf_ram u_ram (
		.clk   (clk),
		.we    (do_insert),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (code_m),
		.re    (ram_re),
		.raddr (rd_ptr_q),
		.rdata (rd_data)
	);

	olns_lane_match u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (mctl),
		.query_code (code_m),
		.level      (lv),
		.rd_data    (rd_data),
		.hit        (hit),
		.hit_idx    (hit_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			level_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rd_ptr_q  <= '0;
			rd_vld_s1 <= 1'b0;
			lane_q    <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q  <= 1'b0;
			rd_vld_s1 <= ram_re;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd.op)
							OP_INSERT: begin
								strobe_q <= 1'b1;
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							OP_QUERY: begin
								rd_ptr_q <= '0;
								lane_q   <= '0;
								state_q  <= (count_q == '0) ? ST_EMIT : ST_SCAN;
							end
							OP_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					rd_ptr_q <= rd_ptr_q + IDX_W'(1);
					if (scan_done) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (hit[lane_q]) begin
						strobe_q <= 1'b1;
					end else if (lane_q == NB_W'(NUM_NB - 1) && hit == '0) begin
						strobe_q <= 1'b1;
					end
					if (lane_q == NB_W'(NUM_NB - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						lane_q <= lane_q + NB_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_ptr_q;
		if (state_q == ST_IDLE) begin
			res_q.result_index <= full ? '0 : OUT_IDX_W'(count_q);
			res_q.valid_res    <= !full;
			res_q.table_full   <= full;
			res_q.last         <= 1'b1;
		end else if (hit[lane_q]) begin
			res_q.result_index <= OUT_IDX_W'(hit_idx[lane_q]);
			res_q.valid_res    <= 1'b1;
			res_q.table_full   <= 1'b0;
			res_q.last         <= ~|(hit & later);
		end else begin
			// lane without a hit; emitted only for an empty neighborhood
			res_q.result_index <= '0;
			res_q.valid_res    <= 1'b0;
			res_q.table_full   <= 1'b0;
			res_q.last         <= 1'b1;
		end
	end

	assign result_strobe = strobe_q;
	assign result        = res_q;

endmodule
